### rtl/dwm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwm_pkg
// Shared types, codes and constants of the decimal word machine executor.
// ----------------------------------------------------------------------------
package dwm_pkg;

  localparam int MEM_WORDS   = 100;
  localparam int MEM_AW      = 7;
  localparam int WORD_W      = 32;
  localparam int BLOCK_WORDS = 10;

  localparam logic [WORD_W-1:0] SPACES = 32'h2020_2020;

  localparam logic [7:0] CH_G    = 8'h47;
  localparam logic [7:0] CH_D    = 8'h44;
  localparam logic [7:0] CH_P    = 8'h50;
  localparam logic [7:0] CH_H    = 8'h48;
  localparam logic [7:0] CH_L    = 8'h4C;
  localparam logic [7:0] CH_S    = 8'h53;
  localparam logic [7:0] CH_C    = 8'h43;
  localparam logic [7:0] CH_B    = 8'h42;
  localparam logic [7:0] CH_T    = 8'h54;
  localparam logic [7:0] CH_R    = 8'h52;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  typedef enum logic [2:0] {
    CMD_START = 3'd0,
    CMD_LOAD  = 3'd1,
    CMD_BEGIN = 3'd2,
    CMD_STEP  = 3'd3,
    CMD_DATA  = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_PRINT = 3'd1,
    ST_WAIT  = 3'd2,
    ST_HALT  = 3'd3,
    ST_ERR   = 3'd4,
    ST_IGN   = 3'd5
  } st_t;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_RUN  = 2'd1,
    MODE_WAIT = 2'd2,
    MODE_HALT = 2'd3
  } mode_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_START,
    OP_LOAD,
    OP_BEGIN,
    OP_SET_HALT,
    OP_FETCH_RD,
    OP_FETCH_WR,
    OP_OPND_RD,
    OP_LR,
    OP_CR,
    OP_SR,
    OP_BT,
    OP_GD,
    OP_PD_INIT,
    OP_PD_RD,
    OP_PD_NEXT,
    OP_DATA_WR,
    OP_ZERO_WR,
    OP_DATA_DONE
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_FETCH,
    S_DECODE,
    S_OPER,
    S_PD_RD,
    S_PD_EMIT,
    S_DATA_CHK
  } state_t;

  typedef struct packed {
    logic [2:0]        command;
    logic [WORD_W-1:0] word;
    logic              card_end;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] out_word;
    logic [2:0]        status;
    logic              last;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    op_t  op;
    logic emit;
    st_t  status;
    logic last;
    logic emit_word;
    logic latch_in;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [2:0] cmd;
    mode_t      mode;
    logic       lp_full;
    logic       ic_over;
    logic       is_gd;
    logic       is_pd;
    logic       is_h;
    logic       is_lr;
    logic       is_sr;
    logic       is_cr;
    logic       is_bt;
    logic       d2_ok;
    logic       two_ok;
    logic       data_ok;
    logic       fill_full;
    logic       card_end;
    logic       pd_last;
    logic       out_free;
  } dp_stat_t;

endpackage

### rtl/dwm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwm_ram
// Generic single-clock RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module dwm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 100
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/dwm_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwm_datapath
// Machine registers, main memory with per-word valid flags, decode and the
// result register.
// ----------------------------------------------------------------------------
module dwm_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  dwm_pkg::in_item_t   in_data,
  input  dwm_pkg::dp_cmd_t    cmd,
  output dwm_pkg::dp_stat_t   stat,
  output logic                out_valid,
  input  logic                out_ready,
  output dwm_pkg::out_item_t  out_data
);

  dwm_pkg::in_item_t              in_r;
  logic [dwm_pkg::MEM_AW-1:0]     ic_r;
  logic [dwm_pkg::WORD_W-1:0]     ir_r;
  logic [dwm_pkg::WORD_W-1:0]     gr_r;
  logic                           cf_r;
  logic [dwm_pkg::MEM_AW-1:0]     lp_r;
  dwm_pkg::mode_t                 mode_r;
  logic [3:0]                     fill_r;
  logic [dwm_pkg::MEM_AW-1:0]     base_r;
  logic [dwm_pkg::MEM_AW-1:0]     pd_base_r;
  logic [3:0]                     pd_idx_r;
  logic [dwm_pkg::MEM_WORDS-1:0]  vld_r;
  logic                           vld_q_r;
  logic                           out_valid_r;
  dwm_pkg::out_item_t             out_r;

  logic [7:0]                     c0, c1, c2, c3;
  logic                           d2_ok, d3_ok;
  logic [dwm_pkg::MEM_AW-1:0]     d2_x10;
  logic [dwm_pkg::MEM_AW-1:0]     opnd_addr;
  logic                           ram_we, ram_re;
  logic [dwm_pkg::MEM_AW-1:0]     ram_addr;
  logic [dwm_pkg::WORD_W-1:0]     ram_wdata;
  logic [dwm_pkg::WORD_W-1:0]     ram_q;
  logic [dwm_pkg::WORD_W-1:0]     rd_word;

  assign c0 = ir_r[31:24];
  assign c1 = ir_r[23:16];
  assign c2 = ir_r[15:8];
  assign c3 = ir_r[7:0];

  assign d2_ok = (c2 >= dwm_pkg::CH_ZERO) && (c2 <= dwm_pkg::CH_NINE);
  assign d3_ok = (c3 >= dwm_pkg::CH_ZERO) && (c3 <= dwm_pkg::CH_NINE);

  // tens digit times ten as 8x + 2x
  assign d2_x10    = {c2[3:0], 3'b000} + {2'b00, c2[3:0], 1'b0};
  assign opnd_addr = d2_x10 + {3'b000, c3[3:0]};

  // never-written words read as spaces
  assign rd_word = vld_q_r ? ram_q : dwm_pkg::SPACES;

  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_addr  = ic_r;
    ram_wdata = in_r.word;
    case (cmd.op)
      dwm_pkg::OP_FETCH_RD: begin
        ram_re = 1'b1;
      end
      dwm_pkg::OP_OPND_RD: begin
        ram_re   = 1'b1;
        ram_addr = opnd_addr;
      end
      dwm_pkg::OP_SR: begin
        ram_we    = 1'b1;
        ram_addr  = opnd_addr;
        ram_wdata = gr_r;
      end
      dwm_pkg::OP_LOAD: begin
        ram_we   = 1'b1;
        ram_addr = lp_r;
      end
      dwm_pkg::OP_PD_RD: begin
        ram_re   = 1'b1;
        ram_addr = pd_base_r + {3'b000, pd_idx_r};
      end
      dwm_pkg::OP_DATA_WR: begin
        ram_we   = 1'b1;
        ram_addr = base_r + {3'b000, fill_r};
      end
      dwm_pkg::OP_ZERO_WR: begin
        ram_we    = 1'b1;
        ram_addr  = base_r + {3'b000, fill_r};
        ram_wdata = '0;
      end
      default: begin
      end
    endcase
  end

  dwm_ram #(
    .WIDTH (dwm_pkg::WORD_W),
    .DEPTH (dwm_pkg::MEM_WORDS)
  ) u_mem (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_addr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_addr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      in_r <= in_data;
    end
    if (ram_re) begin
      vld_q_r <= vld_r[ram_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ic_r      <= '0;
      ir_r      <= dwm_pkg::SPACES;
      gr_r      <= dwm_pkg::SPACES;
      cf_r      <= 1'b0;
      lp_r      <= '0;
      mode_r    <= dwm_pkg::MODE_IDLE;
      fill_r    <= '0;
      base_r    <= '0;
      pd_base_r <= '0;
      pd_idx_r  <= '0;
      vld_r     <= '0;
    end else begin
      if (ram_we) begin
        vld_r[ram_addr] <= 1'b1;
      end
      case (cmd.op)
        dwm_pkg::OP_START: begin
          ic_r   <= '0;
          ir_r   <= dwm_pkg::SPACES;
          gr_r   <= dwm_pkg::SPACES;
          cf_r   <= 1'b0;
          lp_r   <= '0;
          mode_r <= dwm_pkg::MODE_IDLE;
          fill_r <= '0;
          base_r <= '0;
          vld_r  <= '0;
        end
        dwm_pkg::OP_LOAD: begin
          lp_r <= lp_r + 1'b1;
        end
        dwm_pkg::OP_BEGIN: begin
          ic_r   <= '0;
          fill_r <= '0;
          mode_r <= dwm_pkg::MODE_RUN;
        end
        dwm_pkg::OP_SET_HALT: begin
          mode_r <= dwm_pkg::MODE_HALT;
        end
        dwm_pkg::OP_FETCH_WR: begin
          ir_r <= rd_word;
          ic_r <= ic_r + 1'b1;
        end
        dwm_pkg::OP_LR: begin
          gr_r <= rd_word;
        end
        dwm_pkg::OP_CR: begin
          cf_r <= (rd_word == gr_r);
        end
        dwm_pkg::OP_BT: begin
          if (cf_r) begin
            ic_r <= opnd_addr;
          end
        end
        dwm_pkg::OP_GD: begin
          base_r <= d2_x10;
          fill_r <= '0;
          mode_r <= dwm_pkg::MODE_WAIT;
        end
        dwm_pkg::OP_PD_INIT: begin
          pd_base_r <= d2_x10;
          pd_idx_r  <= '0;
        end
        dwm_pkg::OP_PD_NEXT: begin
          pd_idx_r <= pd_idx_r + 1'b1;
        end
        dwm_pkg::OP_DATA_WR, dwm_pkg::OP_ZERO_WR: begin
          fill_r <= fill_r + 1'b1;
        end
        dwm_pkg::OP_DATA_DONE: begin
          fill_r <= '0;
          mode_r <= dwm_pkg::MODE_RUN;
        end
        default: begin
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r.out_word <= cmd.emit_word ? rd_word : '0;
      out_r.status   <= cmd.status;
      out_r.last     <= cmd.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    stat.cmd       = in_r.command;
    stat.mode      = mode_r;
    stat.lp_full   = lp_r >= dwm_pkg::MEM_AW'(dwm_pkg::MEM_WORDS);
    stat.ic_over   = ic_r >= dwm_pkg::MEM_AW'(dwm_pkg::MEM_WORDS);
    stat.is_gd     = (c0 == dwm_pkg::CH_G) && (c1 == dwm_pkg::CH_D);
    stat.is_pd     = (c0 == dwm_pkg::CH_P) && (c1 == dwm_pkg::CH_D);
    stat.is_h      = (c0 == dwm_pkg::CH_H);
    stat.is_lr     = (c0 == dwm_pkg::CH_L) && (c1 == dwm_pkg::CH_R);
    stat.is_sr     = (c0 == dwm_pkg::CH_S) && (c1 == dwm_pkg::CH_R);
    stat.is_cr     = (c0 == dwm_pkg::CH_C) && (c1 == dwm_pkg::CH_R);
    stat.is_bt     = (c0 == dwm_pkg::CH_B) && (c1 == dwm_pkg::CH_T);
    stat.d2_ok     = d2_ok;
    stat.two_ok    = d2_ok && d3_ok;
    stat.data_ok   = (mode_r == dwm_pkg::MODE_WAIT)
                     && (fill_r < 4'(dwm_pkg::BLOCK_WORDS))
                     && (base_r <= dwm_pkg::MEM_AW'(dwm_pkg::MEM_WORDS - dwm_pkg::BLOCK_WORDS));
    stat.fill_full = (fill_r == 4'(dwm_pkg::BLOCK_WORDS));
    stat.card_end  = in_r.card_end;
    stat.pd_last   = (pd_idx_r == 4'(dwm_pkg::BLOCK_WORDS - 1));
    stat.out_free  = !out_valid_r || out_ready;
  end

endmodule

### rtl/dwm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwm_ctrl
// Controller: takes an input item, sequences fetch, decode, execute, print
// and card fill, and schedules each result into the output register.
// ----------------------------------------------------------------------------
module dwm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  dwm_pkg::dp_stat_t  stat,
  output dwm_pkg::dp_cmd_t   cmd
);

  dwm_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dwm_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    in_ready      = 1'b0;
    cmd.op        = dwm_pkg::OP_NONE;
    cmd.emit      = 1'b0;
    cmd.status    = dwm_pkg::ST_OK;
    cmd.last      = 1'b1;
    cmd.emit_word = 1'b0;
    cmd.latch_in  = 1'b0;

    case (state_r)
      dwm_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = dwm_pkg::S_DISPATCH;
        end
      end

      dwm_pkg::S_DISPATCH: begin
        if (stat.out_free) begin
          state_nxt = dwm_pkg::S_IDLE;
          cmd.emit  = 1'b1;
          case (stat.cmd)
            dwm_pkg::CMD_START: begin
              cmd.op = dwm_pkg::OP_START;
            end
            dwm_pkg::CMD_LOAD: begin
              if ((stat.mode == dwm_pkg::MODE_IDLE || stat.mode == dwm_pkg::MODE_HALT)
                  && !stat.lp_full) begin
                cmd.op = dwm_pkg::OP_LOAD;
              end else begin
                cmd.status = dwm_pkg::ST_IGN;
              end
            end
            dwm_pkg::CMD_BEGIN: begin
              cmd.op = dwm_pkg::OP_BEGIN;
            end
            dwm_pkg::CMD_STEP: begin
              case (stat.mode)
                dwm_pkg::MODE_WAIT: cmd.status = dwm_pkg::ST_WAIT;
                dwm_pkg::MODE_HALT: cmd.status = dwm_pkg::ST_HALT;
                dwm_pkg::MODE_RUN: begin
                  if (stat.ic_over) begin
                    cmd.op     = dwm_pkg::OP_SET_HALT;
                    cmd.status = dwm_pkg::ST_ERR;
                  end else begin
                    cmd.op    = dwm_pkg::OP_FETCH_RD;
                    cmd.emit  = 1'b0;
                    state_nxt = dwm_pkg::S_FETCH;
                  end
                end
                default: cmd.status = dwm_pkg::ST_IGN;
              endcase
            end
            dwm_pkg::CMD_DATA: begin
              if (stat.data_ok) begin
                cmd.op    = dwm_pkg::OP_DATA_WR;
                cmd.emit  = 1'b0;
                state_nxt = dwm_pkg::S_DATA_CHK;
              end else begin
                cmd.status = dwm_pkg::ST_IGN;
              end
            end
            default: begin
              cmd.status = dwm_pkg::ST_IGN;
            end
          endcase
        end
      end

      dwm_pkg::S_FETCH: begin
        cmd.op    = dwm_pkg::OP_FETCH_WR;
        state_nxt = dwm_pkg::S_DECODE;
      end

      dwm_pkg::S_DECODE: begin
        if (stat.out_free) begin
          state_nxt  = dwm_pkg::S_IDLE;
          cmd.emit   = 1'b1;
          cmd.status = dwm_pkg::ST_ERR;
          if (stat.is_gd) begin
            if (stat.d2_ok) begin
              cmd.op     = dwm_pkg::OP_GD;
              cmd.status = dwm_pkg::ST_WAIT;
            end
          end else if (stat.is_pd) begin
            if (stat.d2_ok) begin
              cmd.op    = dwm_pkg::OP_PD_INIT;
              cmd.emit  = 1'b0;
              state_nxt = dwm_pkg::S_PD_RD;
            end
          end else if (stat.is_h) begin
            cmd.op     = dwm_pkg::OP_SET_HALT;
            cmd.status = dwm_pkg::ST_HALT;
          end else if (stat.is_lr || stat.is_cr) begin
            if (stat.two_ok) begin
              cmd.op    = dwm_pkg::OP_OPND_RD;
              cmd.emit  = 1'b0;
              state_nxt = dwm_pkg::S_OPER;
            end
          end else if (stat.is_sr || stat.is_bt) begin
            if (stat.two_ok) begin
              cmd.op     = stat.is_sr ? dwm_pkg::OP_SR : dwm_pkg::OP_BT;
              cmd.status = dwm_pkg::ST_OK;
            end
          end else begin
            cmd.status = dwm_pkg::ST_IGN;
          end
        end
      end

      dwm_pkg::S_OPER: begin
        if (stat.out_free) begin
          cmd.op    = stat.is_lr ? dwm_pkg::OP_LR : dwm_pkg::OP_CR;
          cmd.emit  = 1'b1;
          state_nxt = dwm_pkg::S_IDLE;
        end
      end

      dwm_pkg::S_PD_RD: begin
        cmd.op    = dwm_pkg::OP_PD_RD;
        state_nxt = dwm_pkg::S_PD_EMIT;
      end

      dwm_pkg::S_PD_EMIT: begin
        if (stat.out_free) begin
          cmd.op        = dwm_pkg::OP_PD_NEXT;
          cmd.emit      = 1'b1;
          cmd.emit_word = 1'b1;
          cmd.status    = dwm_pkg::ST_PRINT;
          cmd.last      = stat.pd_last;
          state_nxt     = stat.pd_last ? dwm_pkg::S_IDLE : dwm_pkg::S_PD_RD;
        end
      end

      dwm_pkg::S_DATA_CHK: begin
        // a short card loops here writing zero words until the block is full
        if (stat.out_free) begin
          if (stat.fill_full) begin
            cmd.op    = dwm_pkg::OP_DATA_DONE;
            cmd.emit  = 1'b1;
            state_nxt = dwm_pkg::S_IDLE;
          end else if (!stat.card_end) begin
            cmd.emit   = 1'b1;
            cmd.status = dwm_pkg::ST_WAIT;
            state_nxt  = dwm_pkg::S_IDLE;
          end else begin
            cmd.op = dwm_pkg::OP_ZERO_WR;
          end
        end
      end

      default: begin
        state_nxt = dwm_pkg::S_IDLE;
      end
    endcase
  end

endmodule

### rtl/decimal_word_machine_executor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_word_machine_executor
// Teaching machine with 100 four-character words: job start, program load,
// begin, single step and data card input, one or ten results per item.
// ----------------------------------------------------------------------------
// start, load, begin and rejected items go straight to the result register; a step
//   first fetches, decodes and for LR or CR reads its operand, a data word first pads a short card
// PD prints ten words, each read from memory through the registered read port before it leaves
// next item is taken once the last result sits in the output register
// reset and start job clear the per-word valid flags (read as spaces)
module decimal_word_machine_executor (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  dwm_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output dwm_pkg::out_item_t  out_data
);

  dwm_pkg::dp_cmd_t  cmd;
  dwm_pkg::dp_stat_t stat;

  dwm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dwm_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### tb/sv/dwm_scoreboard_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwm_scoreboard_pkg
// Machine predictor and result scoreboard for the decimal word machine
// executor testbench.
// ----------------------------------------------------------------------------
package dwm_scoreboard_pkg;
  import dwm_pkg::*;

  class word_machine_scoreboard;
    logic [WORD_W-1:0] mem [MEM_WORDS];
    logic [MEM_AW-1:0] ic;
    logic [WORD_W-1:0] ir;
    logic [WORD_W-1:0] gr;
    bit                cflag;
    logic [MEM_AW-1:0] lp;
    mode_t             mode;
    int                fill;
    int                base;

    out_item_t   expected_results[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
      clear_job();
    endfunction

    function void clear_job();
      foreach (mem[i]) mem[i] = SPACES;
      ic    = '0;
      ir    = SPACES;
      gr    = SPACES;
      cflag = 1'b0;
      lp    = '0;
      mode  = MODE_IDLE;
      fill  = 0;
      base  = 0;
    endfunction

    function void push(logic [WORD_W-1:0] w, st_t st, bit lst);
      out_item_t r;
      r.out_word = w;
      r.status   = st;
      r.last     = lst;
      expected_results.push_back(r);
    endfunction

    function void reply(st_t st);
      push('0, st, 1'b1);
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function int digit_value(logic [7:0] c);
      return int'(c - CH_ZERO);
    endfunction

    function void exec_step();
      logic [7:0] c0, c1, c2, c3;
      bit         two_ok;
      int         addr;
      if (mode == MODE_WAIT) begin
        reply(ST_WAIT);
        return;
      end
      if (mode == MODE_HALT) begin
        reply(ST_HALT);
        return;
      end
      if (mode != MODE_RUN) begin
        reply(ST_IGN);
        return;
      end
      // counter ran off the end of memory
      if (ic >= MEM_WORDS) begin
        mode = MODE_HALT;
        reply(ST_ERR);
        return;
      end
      ir = mem[ic];
      ic = ic + 7'd1;
      {c0, c1, c2, c3} = ir;
      two_ok = is_digit(c2) && is_digit(c3);
      addr   = two_ok ? digit_value(c2) * 10 + digit_value(c3) : 0;

      if (c0 == CH_G && c1 == CH_D) begin
        if (!is_digit(c2)) begin
          reply(ST_ERR);
          return;
        end
        base = digit_value(c2) * BLOCK_WORDS;
        fill = 0;
        mode = MODE_WAIT;
        reply(ST_WAIT);
        return;
      end
      if (c0 == CH_P && c1 == CH_D) begin
        if (!is_digit(c2)) begin
          reply(ST_ERR);
          return;
        end
        for (int i = 0; i < BLOCK_WORDS; i++)
          push(mem[digit_value(c2) * BLOCK_WORDS + i], ST_PRINT, i == BLOCK_WORDS - 1);
        return;
      end
      if (c0 == CH_H) begin
        mode = MODE_HALT;
        reply(ST_HALT);
        return;
      end
      if ((c1 == CH_R && (c0 == CH_L || c0 == CH_S || c0 == CH_C)) ||
          (c0 == CH_B && c1 == CH_T)) begin
        // the branch checks its operand even when it is not taken
        if (!two_ok) begin
          reply(ST_ERR);
          return;
        end
        if (c0 == CH_L)
          gr = mem[addr];
        else if (c0 == CH_S)
          mem[addr] = gr;
        else if (c0 == CH_C)
          cflag = (mem[addr] == gr);
        else if (cflag)
          ic = addr[MEM_AW-1:0];
        reply(ST_OK);
        return;
      end
      reply(ST_IGN);
    endfunction

    function void take_data(logic [WORD_W-1:0] w, bit ce);
      if (mode != MODE_WAIT || fill >= BLOCK_WORDS || base > MEM_WORDS - BLOCK_WORDS) begin
        reply(ST_IGN);
        return;
      end
      mem[base + fill] = w;
      fill++;
      if (!ce && fill < BLOCK_WORDS) begin
        reply(ST_WAIT);
        return;
      end
      // short card: rest of the block reads as zero
      for (int k = fill; k < BLOCK_WORDS; k++)
        mem[base + k] = '0;
      fill = 0;
      mode = MODE_RUN;
      reply(ST_OK);
    endfunction

    function void record_command(in_item_t it);
      case (it.command)
        CMD_START: begin
          clear_job();
          reply(ST_OK);
        end
        CMD_LOAD: begin
          if ((mode == MODE_IDLE || mode == MODE_HALT) && lp < MEM_WORDS) begin
            mem[lp] = it.word;
            lp      = lp + 7'd1;
            reply(ST_OK);
          end else begin
            reply(ST_IGN);
          end
        end
        CMD_BEGIN: begin
          ic   = '0;
          fill = 0;
          mode = MODE_RUN;
          reply(ST_OK);
        end
        CMD_STEP: exec_step();
        CMD_DATA: take_data(it.word, it.card_end);
        default:  reply(ST_IGN);
      endcase
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: out_word=%h status=%0d last=%0d",
                   got.out_word, got.status, got.last);
        return;
      end
      want = expected_results.pop_front();
      if (got.out_word !== want.out_word || got.status !== want.status ||
          got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"result mismatch: expected word=%h status=%0d last=%0d,",
                    " got word=%h status=%0d last=%0d"},
                   want.out_word, want.status, want.last,
                   got.out_word, got.status, got.last);
      end
    endfunction
  endclass

endpackage

### tb/sv/tb_decimal_word_machine_executor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_decimal_word_machine_executor
// Drives job start, program load, begin, step and data card transfers into
// the word machine and checks every result against a built-in predictor,
// under several sender idle and receiver stall mixes.
// ----------------------------------------------------------------------------
module tb_decimal_word_machine_executor;
  import dwm_pkg::*;
  import dwm_scoreboard_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200_000;
  localparam int          DRAIN_CYCLES = 40;
  localparam int          PHASE_ITEMS  = 100;
  localparam int          HOLD_CYCLES  = 300;

  // command codes the block does not define
  localparam logic [2:0] CMD_SPARE_LO = 3'd5;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;
  localparam logic [7:0] CH_X         = 8'h58;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  word_machine_scoreboard sb;

  int          snd_idle;
  int          rcv_stall;
  int unsigned hold_cycles;
  int          n_counted;
  int unsigned cycle_count;

  decimal_word_machine_executor i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] digit(int n);
    return CH_ZERO + 8'(n);
  endfunction

  function automatic logic [31:0] pack4(logic [7:0] b0, logic [7:0] b1,
                                        logic [7:0] b2, logic [7:0] b3);
    return {b0, b1, b2, b3};
  endfunction

  function automatic logic [7:0] non_digit();
    logic [7:0] v;
    do
      v = 8'($urandom);
    while (v >= CH_ZERO && v <= CH_NINE);
    return v;
  endfunction

  // random instruction word, biased toward low addresses so compares can hit
  function automatic logic [31:0] rand_instr();
    int         r;
    int         opi;
    int         addr;
    logic [7:0] op0, op1, a2, a3;
    addr = ($urandom_range(3) == 0) ? $urandom_range(99) : $urandom_range(29);
    a2   = digit(addr / 10);
    a3   = digit(addr % 10);
    r    = $urandom_range(19);
    if (r == 5)
      return {CH_H, 24'($urandom)};
    if (r == 16)
      return $urandom;
    opi = (r <= 2) ? 0 : (r <= 4) ? 1 : (r <= 8) ? 2 : (r <= 10) ? 3 :
          (r <= 13) ? 4 : (r <= 15) ? 5 : $urandom_range(5);
    case (opi)
      0:       {op0, op1} = {CH_G, CH_D};
      1:       {op0, op1} = {CH_P, CH_D};
      2:       {op0, op1} = {CH_L, CH_R};
      3:       {op0, op1} = {CH_S, CH_R};
      4:       {op0, op1} = {CH_C, CH_R};
      default: {op0, op1} = {CH_B, CH_T};
    endcase
    // block ops ignore the fourth character
    if (opi <= 1 && $urandom_range(1) == 1)
      a3 = 8'($urandom);
    if (r >= 17) begin
      if ($urandom_range(1) == 1)
        a2 = non_digit();
      else
        a3 = non_digit();
    end
    return pack4(op0, op1, a2, a3);
  endfunction

  function automatic logic [31:0] data_word();
    return ($urandom_range(2) == 0) ? rand_instr() : $urandom;
  endfunction

  task automatic send_item(logic [2:0] cmd, logic [31:0] w, bit ce);
    in_item_t it;
    it.command  = cmd;
    it.word     = w;
    it.card_end = ce;
    if (snd_idle != 0 && $urandom_range(99) < snd_idle) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.record_command(it);
    n_counted++;
    @(negedge clk);
  endtask

  task automatic run_directed();
    send_item(CMD_START, '0, 1'b0);
    send_item(CMD_LOAD, pack4(CH_G, CH_D, digit(2), CH_ZERO), 1'b0);
    send_item(CMD_LOAD, pack4(CH_P, CH_D, digit(2), CH_ZERO), 1'b1);
    send_item(CMD_LOAD, pack4(CH_C, CH_R, CH_X, CH_NINE), 1'b0);
    send_item(CMD_LOAD, pack4(CH_L, CH_R, digit(2), digit(1)), 1'b0);
    send_item(CMD_LOAD, pack4(CH_S, CH_R, CH_NINE, CH_NINE), 1'b0);
    send_item(CMD_LOAD, pack4(CH_C, CH_R, CH_NINE, CH_NINE), 1'b0);
    send_item(CMD_LOAD, pack4(CH_B, CH_T, CH_NINE, CH_NINE), 1'b0);
    send_item(CMD_BEGIN, '1, 1'b1);
    send_item(CMD_STEP, '0, 1'b0);
    // step and load while the machine waits for a card
    send_item(CMD_STEP, '1, 1'b1);
    send_item(CMD_LOAD, '1, 1'b1);
    // two-word short card, rest of the block zero-filled
    send_item(CMD_DATA, '1, 1'b0);
    send_item(CMD_DATA, '0, 1'b1);
    // print, bad operand, load, store, compare, branch to 99, blank word 99, run off the end, halted
    repeat (9) send_item(CMD_STEP, '0, 1'b0);
    send_item(CMD_DATA, '1, 1'b1);
    send_item(CMD_SPARE_LO, '1, 1'b1);
    send_item(CMD_SPARE_HI, '0, 1'b0);
    send_item(CMD_START, '1, 1'b1);
    send_item(CMD_STEP, '0, 1'b0);
    send_item(CMD_LOAD, {CH_H, SPACES[23:0]}, 1'b0);
    send_item(CMD_BEGIN, '0, 1'b0);
    send_item(CMD_STEP, '0, 1'b0);
  endtask

  task automatic random_job(bit fill_memory);
    int len;
    int budget;
    if (fill_memory || $urandom_range(4) != 0)
      send_item(CMD_START, $urandom, 1'($urandom_range(1)));
    len = fill_memory ? MEM_WORDS + 2 : $urandom_range(2, 12);
    repeat (len) send_item(CMD_LOAD, rand_instr(), 1'($urandom_range(1)));
    send_item(CMD_BEGIN, $urandom, 1'($urandom_range(1)));
    // an occasional long run lets the counter walk past the last word
    budget = ($urandom_range(7) == 0) ? 110 : $urandom_range(5, 30);
    while (budget > 0) begin
      budget--;
      if (sb.mode == MODE_WAIT) begin
        send_item(CMD_DATA, data_word(), $urandom_range(3) == 0);
      end else if (sb.mode == MODE_HALT) begin
        if ($urandom_range(2) != 0)
          break;
        send_item(CMD_BEGIN, $urandom, 1'($urandom_range(1)));
      end else if ($urandom_range(99) < 6) begin
        send_item(3'($urandom_range(7)), $urandom, 1'($urandom_range(1)));
      end else begin
        send_item(CMD_STEP, $urandom, 1'($urandom_range(1)));
      end
    end
  endtask

  // receiver: random stalls plus a long hold-off when requested
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles != 0) begin
        out_ready = 1'b0;
        hold_cycles--;
      end else begin
        out_ready = ($urandom_range(99) >= rcv_stall);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_data);
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    int ph;
    int target;
    bit first;
    sb          = new();
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    snd_idle    = 0;
    rcv_stall   = 0;
    hold_cycles = 0;
    n_counted   = 0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    run_directed();

    target = n_counted;
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          snd_idle    = 0;
          rcv_stall   = 0;
          // long receiver hold-off while the sender keeps offering
          hold_cycles = HOLD_CYCLES;
        end
        1: begin
          snd_idle  = 57;
          rcv_stall = 0;
        end
        2: begin
          snd_idle  = 0;
          rcv_stall = 57;
        end
        default: begin
          snd_idle  = 37;
          rcv_stall = 37;
        end
      endcase
      target += PHASE_ITEMS;
      first = 1'b1;
      while (n_counted < target) begin
        random_job(ph == 1 && first);
        first = 1'b0;
      end
    end
    in_valid = 1'b0;

    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0 && sb.expected_results.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
